// ===== hdl/tpsc_pkg.sv =====
// Shared constants, command and status types for the triangle surface curl block.
`timescale 1ns / 1ps
`default_nettype none
package tpsc_pkg;

  localparam int COORD_WIDTH_DEF      = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 30;

  // Accumulator width of the multiply-accumulate unit; numerators stay below 2^98.
  localparam int ACCW   = 104;
  // Multiplier operand width (edge component or normal component, sign-extended).
  localparam int YW     = 34;
  // Dividend width of the restoring divider.
  localparam int DW     = 100;
  // Number of multiply-accumulate steps per triangle.
  localparam int NSTEP  = 13;
  localparam int STEP_W = 4;
  localparam int CNT_W  = 7;

  localparam logic [1:0] REQ_NORMAL = 2'd3;
  localparam logic [1:0] COMP_Z     = 2'd2;
  localparam logic [1:0] NUM_SEL0   = 2'd0;
  localparam logic [1:0] NUM_SEL1   = 2'd1;
  localparam logic [1:0] NUM_SEL2   = 2'd2;

  typedef struct packed {
    logic              capture;
    logic              mac_load;
    logic              mac_run;
    logic              mac_msb;
    logic [STEP_W-1:0] step;
    logic              div_load;
    logic              div_run;
    logic              div_last;
    logic [1:0]        div_sel;
    logic              out_load;
  } tpsc_cmd_t;

  typedef struct packed {
    logic area_zero;
  } tpsc_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tpsc_ctrl.sv =====
// Sequencer for the triangle surface curl block: handshakes, step and bit counters.
`timescale 1ns / 1ps
`default_nettype none
module tpsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_type,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire tpsc_pkg::tpsc_stat_t stat,
  output tpsc_pkg::tpsc_cmd_t      cmd
);
  import tpsc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHK   = 7'b0000010,
    S_MLOAD = 7'b0000100,
    S_MRUN  = 7'b0001000,
    S_DLOAD = 7'b0010000,
    S_DRUN  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [1:0]        sel, sel_next;
  logic              out_valid_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cnt_next   = cnt;
    sel_next   = sel;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = step;
    cmd.div_sel = sel;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid && in_type == REQ_NORMAL) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        step_next  = '0;
        state_next = stat.area_zero ? S_FIN : S_MLOAD;
      end
      S_MLOAD: begin
        cmd.mac_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_MRUN;
      end
      S_MRUN: begin
        cmd.mac_run = 1'b1;
        cmd.mac_msb = (cnt == CNT_W'(YW - 1));
        if (cmd.mac_msb) begin
          if (step == STEP_W'(NSTEP - 1)) begin
            sel_next   = NUM_SEL0;
            state_next = S_DLOAD;
          end else begin
            step_next  = step + STEP_W'(1);
            state_next = S_MLOAD;
          end
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DRUN;
      end
      S_DRUN: begin
        cmd.div_run  = 1'b1;
        cmd.div_last = (cnt == CNT_W'(DW - 1));
        if (cmd.div_last) begin
          if (sel == NUM_SEL2) begin
            state_next = S_FIN;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = S_DLOAD;
          end
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      cnt       <= '0;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      cnt       <= cnt_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tpsc_dp.sv =====
// Datapath: vertex and normal registers, bit-serial multiply-accumulate, divider, rounding.
`timescale 1ns / 1ps
`default_nettype none
module tpsc_dp #(
  parameter int COORD_WIDTH      = tpsc_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tpsc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tpsc_pkg::tpsc_cmd_t  cmd,
  output tpsc_pkg::tpsc_stat_t      stat,
  input  wire logic [127:0]         in_data,
  input  wire logic [1:0]           in_type,
  input  wire logic                 in_last,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_data,
  output logic [95:0]               out_data,
  output logic                      out_deg,
  output logic                      out_last
);
  import tpsc_pkg::*;

  localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int AW = CW + 1;
  localparam int RS = 2 * NORMAL_FRAC_BITS - 16;

  logic signed [CW-1:0]   vtx [3][3];
  logic signed [31:0]     nrm [3];
  logic [31:0]            area;
  logic                   last_r;
  logic [1:0]             comp;

  logic signed [ACCW-1:0] nn, s1, s2, num1, num2;
  logic signed [ACCW-1:0] xr, acc, acc_next, term, x_sel;
  logic signed [YW-1:0]   yr, y_sel;
  logic                   sub_r, clr_sel, sub_sel;

  logic [DW-1:0]          dvd, dvd_next;
  logic [32:0]            rem, rem2, rem_next;
  logic                   neg_r, ge;
  logic signed [ACCW-1:0] num_sel, num_mag;
  logic [31:0]            res [3];

  logic [1:0]             d;
  logic signed [AW-1:0]   a1 [3];
  logic signed [AW-1:0]   a2 [3];

  // Rounds half away from zero after the fixed-point shift, then clamps.
  function automatic logic [31:0] rnd_sat(input logic [DW-1:0] q, input logic neg);
    logic [DW-1:0] qs;
    logic [DW:0]   r;
    qs = q >> RS;
    r  = ({1'b0, qs} + (DW + 1)'(1)) >> 1;
    if (neg) begin
      if (r > (DW + 1)'(33'h080000000)) begin
        rnd_sat = 32'h80000000;
      end else begin
        rnd_sat = ~r[31:0] + 32'd1;
      end
    end else begin
      if (r > (DW + 1)'(32'h7FFFFFFF)) begin
        rnd_sat = 32'h7FFFFFFF;
      end else begin
        rnd_sat = r[31:0];
      end
    end
  endfunction

  assign d              = (comp > COMP_Z) ? COMP_Z : comp;
  assign stat.area_zero = (area == 32'd0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a1[i] = AW'(vtx[1][i]) - AW'(vtx[0][i]);
      a2[i] = AW'(vtx[2][i]) - AW'(vtx[0][i]);
    end
  end

  // Operand selection per step: n.n, n.a1, n.a2, then the two numerators.
  always_comb begin
    x_sel   = '0;
    y_sel   = '0;
    clr_sel = 1'b0;
    sub_sel = 1'b0;
    case (cmd.step)
      4'd0:  begin x_sel = ACCW'(nrm[0]); y_sel = YW'(nrm[0]); clr_sel = 1'b1; end
      4'd1:  begin x_sel = ACCW'(nrm[1]); y_sel = YW'(nrm[1]); end
      4'd2:  begin x_sel = ACCW'(nrm[2]); y_sel = YW'(nrm[2]); end
      4'd3:  begin x_sel = ACCW'(a1[0]);  y_sel = YW'(nrm[0]); clr_sel = 1'b1; end
      4'd4:  begin x_sel = ACCW'(a1[1]);  y_sel = YW'(nrm[1]); end
      4'd5:  begin x_sel = ACCW'(a1[2]);  y_sel = YW'(nrm[2]); end
      4'd6:  begin x_sel = ACCW'(a2[0]);  y_sel = YW'(nrm[0]); clr_sel = 1'b1; end
      4'd7:  begin x_sel = ACCW'(a2[1]);  y_sel = YW'(nrm[1]); end
      4'd8:  begin x_sel = ACCW'(a2[2]);  y_sel = YW'(nrm[2]); end
      4'd9:  begin x_sel = nn; y_sel = YW'(a2[d]);  clr_sel = 1'b1; end
      4'd10: begin x_sel = s2; y_sel = YW'(nrm[d]); sub_sel = 1'b1; end
      4'd11: begin x_sel = s1; y_sel = YW'(nrm[d]); clr_sel = 1'b1; end
      4'd12: begin x_sel = nn; y_sel = YW'(a1[d]);  sub_sel = 1'b1; end
      default: begin x_sel = '0; y_sel = '0; end
    endcase
  end

  // The multiplier sign bit carries negative weight.
  assign term     = yr[0] ? xr : '0;
  assign acc_next = (cmd.mac_msb ^ sub_r) ? acc - term : acc + term;

  always_comb begin
    case (cmd.div_sel)
      NUM_SEL0: num_sel = -(num1 + num2);
      NUM_SEL1: num_sel = num1;
      default:  num_sel = num2;
    endcase
    num_mag = num_sel[ACCW-1] ? -num_sel : num_sel;
  end

  assign rem2     = {rem[31:0], dvd[DW-1]};
  assign ge       = (rem2 >= {1'b0, area});
  assign rem_next = ge ? rem2 - {1'b0, area} : rem2;
  assign dvd_next = {dvd[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      comp <= '0;
    end else if (cfg_we) begin
      comp <= cfg_data;
    end
    if (cmd.capture) begin
      if (in_type == REQ_NORMAL) begin
        nrm[0] <= in_data[31:0];
        nrm[1] <= in_data[63:32];
        nrm[2] <= in_data[95:64];
        area   <= in_data[127:96];
        last_r <= in_last;
      end else begin
        vtx[in_type][0] <= in_data[CW-1:0];
        vtx[in_type][1] <= in_data[32+CW-1:32];
        vtx[in_type][2] <= in_data[64+CW-1:64];
      end
    end
    if (cmd.mac_load) begin
      xr    <= x_sel;
      yr    <= y_sel;
      sub_r <= sub_sel;
      if (clr_sel) begin
        acc <= '0;
      end
    end
    if (cmd.mac_run) begin
      xr  <= xr <<< 1;
      yr  <= yr >>> 1;
      acc <= acc_next;
      if (cmd.mac_msb) begin
        case (cmd.step) inside
          [4'd0:4'd2]:  nn   <= acc_next;
          [4'd3:4'd5]:  s1   <= acc_next;
          [4'd6:4'd8]:  s2   <= acc_next;
          [4'd9:4'd10]: num1 <= acc_next;
          default:      num2 <= acc_next;
        endcase
      end
    end
    if (cmd.div_load) begin
      dvd   <= num_mag[DW-1:0];
      rem   <= '0;
      neg_r <= num_sel[ACCW-1];
    end
    if (cmd.div_run) begin
      dvd <= dvd_next;
      rem <= rem_next;
      if (cmd.div_last) begin
        res[cmd.div_sel] <= rnd_sat(dvd_next, neg_r);
      end
    end
    if (cmd.out_load) begin
      out_deg  <= stat.area_zero;
      out_last <= last_r;
      out_data <= stat.area_zero ? '0 : {res[2], res[1], res[0]};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/triangle_p1_surface_curl.sv =====
// Top level of the triangle surface curl block: ports, controller and datapath.
// A vertex word is taken while the block is idle; a normal word yields its result word
// once the bit-serial multiply-accumulate unit and the restoring divider have run, one
// bit per cycle each. No new input word is taken until the current triangle is done;
// a zero-area triangle skips the multiply-accumulate steps and the divisions.
// Reset (rst, synchronous, active high) clears the controller, output valid and component.
`timescale 1ns / 1ps
`default_nettype none
module triangle_p1_surface_curl #(
  parameter int COORD_WIDTH      = tpsc_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tpsc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input words: one per vertex, then the normal plus area that starts the computation.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // comp_x, comp_y, comp_z, tri_area
  input  wire logic [1:0]   s_axis_tuser,  // req_type
  input  wire logic         s_axis_tlast,  // last_in
  // Result words, one per normal word.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // curl_node0, curl_node1, curl_node2
  output logic [0:0]        m_axis_tuser,  // degenerate
  output logic              m_axis_tlast,  // last_out
  // Component select register, writable whenever the block is idle.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_data
);
  import tpsc_pkg::*;

  tpsc_cmd_t  cmd;
  tpsc_stat_t stat;

  // The register write never stalls.
  assign cfg_ready = 1'b1;

  // The controller walks 13 multiply-accumulate steps (n.n, n.a1, n.a2 and the two
  // numerators, using n x (a x n) = a(n.n) - n(n.a)), then three divisions by the area.
  // The finished word sits in an output register so the block is free while it waits.
  tpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_type   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpsc_dp #(
    .COORD_WIDTH      (COORD_WIDTH),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .in_type  (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (m_axis_tdata),
    .out_deg  (m_axis_tuser[0]),
    .out_last (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/tpsc_chk.sv =====
// Port-level checks for the triangle surface curl block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tpsc_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [95:0]  m_axis_tdata,
  input wire logic [0:0]   m_axis_tuser
);
  import tpsc_pkg::*;

  // A held result word keeps its data.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A degenerate triangle gives all-zero curls.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 96'd0)
    else $error("degenerate result not zero");

  // The normal word starts a computation, so input is closed on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_NORMAL |=> !s_axis_tready)
    else $error("input open right after a normal word");

endmodule

bind triangle_p1_surface_curl tpsc_chk u_tpsc_chk (.*);
`default_nettype wire
